[hw/rtl/rgbhsv_pkg.sv]
// Shared widths, sector codes and beat types of the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int COMPONENT_BITS = 8;
  localparam int FRACTION_BITS  = 16;

  // Hue and saturation span 0 .. 2^FRACTION_BITS inclusive.
  localparam int RESULT_BITS = FRACTION_BITS + 1;
  // One integer quotient bit plus one fraction bit beyond the result for rounding.
  localparam int QUO_BITS = FRACTION_BITS + 2;
  // Hue numerator and divisor reach six times the component range.
  localparam int NUM_BITS = COMPONENT_BITS + 3;

  // Which component is the minimum; it selects the hue sector.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
    logic [COMPONENT_BITS-1:0] opacity;
  } pixel_t;

  typedef struct packed {
    logic [RESULT_BITS-1:0]    hue;
    logic [RESULT_BITS-1:0]    saturation;
    logic [COMPONENT_BITS-1:0] brightness;
    logic [COMPONENT_BITS-1:0] opacity_out;
  } hsv_t;

  // Front end result handed to the dividers and the sideband line.
  typedef struct packed {
    logic                      valid;
    logic                      grey;
    logic [COMPONENT_BITS-1:0] brightness;
    logic [COMPONENT_BITS-1:0] opacity;
    logic [NUM_BITS-1:0]       hue_num;
    logic [NUM_BITS-1:0]       hue_den;
    logic [COMPONENT_BITS-1:0] sat_num;
  } front_t;

endpackage

[hw/rtl/rgbhsv_front.sv]
// Front end: extrema and sector in the first stage, numerators and divisors in the second.
module rgbhsv_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  pixel_valid,
  input  rgbhsv_pkg::pixel_t    pixel,
  output rgbhsv_pkg::front_t    front
);

  localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
  localparam int NB = rgbhsv_pkg::NUM_BITS;

  // Stage one registers.
  logic                s1_valid;
  rgbhsv_pkg::pixel_t  s1_pix;
  logic [CB-1:0]       s1_max;
  logic [CB-1:0]       s1_min;
  logic [1:0]          s1_sector;

  // Stage two registers.
  logic                s2_valid;
  logic                s2_grey;
  logic [CB-1:0]       s2_max;
  logic [CB-1:0]       s2_opacity;
  logic [NB-1:0]       s2_hue_num;
  logic [NB-1:0]       s2_hue_den;
  logic [CB-1:0]       s2_diff;

  logic                red_min;
  logic                green_min;
  logic [CB-1:0]       max_next;
  logic [CB-1:0]       min_next;
  logic [1:0]          sector_next;

  logic [CB-1:0]       diff;
  logic [NB-1:0]       diff_ext;
  logic [NB-1:0]       hue_num_next;

  // Red wins ties for the minimum, then green.
  always_comb begin
    red_min   = (pixel.red <= pixel.green) && (pixel.red <= pixel.blue);
    green_min = !red_min && (pixel.green <= pixel.blue);
    if (red_min) begin
      sector_next = rgbhsv_pkg::SEC_RED;
      min_next    = pixel.red;
    end else if (green_min) begin
      sector_next = rgbhsv_pkg::SEC_GREEN;
      min_next    = pixel.green;
    end else begin
      sector_next = rgbhsv_pkg::SEC_BLUE;
      min_next    = pixel.blue;
    end
    max_next = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    if (pixel.blue > max_next) begin
      max_next = pixel.blue;
    end
  end

  // The numerator is offset*d minus the sector term; it never goes negative,
  // so modular arithmetic at this width gives the exact value.
  always_comb begin
    diff     = s1_max - s1_min;
    diff_ext = {{(NB-CB){1'b0}}, diff};
    case (s1_sector)
      rgbhsv_pkg::SEC_RED: begin
        hue_num_next = diff_ext + (diff_ext << 1)
                     + {{(NB-CB){1'b0}}, s1_pix.blue} - {{(NB-CB){1'b0}}, s1_pix.green};
      end
      rgbhsv_pkg::SEC_GREEN: begin
        hue_num_next = diff_ext + (diff_ext << 2)
                     + {{(NB-CB){1'b0}}, s1_pix.red} - {{(NB-CB){1'b0}}, s1_pix.blue};
      end
      default: begin
        hue_num_next = diff_ext
                     + {{(NB-CB){1'b0}}, s1_pix.green} - {{(NB-CB){1'b0}}, s1_pix.red};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix     <= pixel;
      s1_max     <= max_next;
      s1_min     <= min_next;
      s1_sector  <= sector_next;
      s2_grey    <= (diff == '0);
      s2_max     <= s1_max;
      s2_opacity <= s1_pix.opacity;
      s2_hue_num <= hue_num_next;
      s2_hue_den <= (diff_ext << 1) + (diff_ext << 2);
      s2_diff    <= diff;
    end
  end

  assign front.valid      = s2_valid;
  assign front.grey       = s2_grey;
  assign front.brightness = s2_max;
  assign front.opacity    = s2_opacity;
  assign front.hue_num    = s2_hue_num;
  assign front.hue_den    = s2_hue_den;
  assign front.sat_num    = s2_diff;

endmodule

[hw/rtl/rgbhsv_divider.sv]
// Pipelined restoring divider, one quotient bit per register stage, for a numerator no larger than the divisor.
module rgbhsv_divider #(
  parameter int DEN_BITS = rgbhsv_pkg::NUM_BITS,
  parameter int QUO_BITS = rgbhsv_pkg::QUO_BITS
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DEN_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [QUO_BITS-1:0] quo
);

  // Quotient is floor(num * 2^(QUO_BITS-1) / den); the first stage yields the integer bit.
  logic [DEN_BITS-1:0] rem_q [QUO_BITS];
  logic [DEN_BITS-1:0] den_q [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS];

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS-1:0] den_in;
    logic [QUO_BITS-1:0] quo_in;
    logic                bit_q;

    if (s == 0) begin : g_first
      assign trial  = {1'b0, num};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign trial  = {rem_q[s-1], 1'b0};
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign bit_q = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= bit_q ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QUO_BITS-2:0], bit_q};
      end
    end
  end

  assign quo = quo_q[QUO_BITS-1];

endmodule

[hw/rtl/rgb_to_hsv.sv]
// Top level of the RGB to HSV pixel converter: front end, two dividers and the output stage.
// Throughput: one pixel per cycle while the output does not stall; each divider spends one
// register stage per quotient bit.
// The whole pipeline advances together and holds while a finished beat waits on the output.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
module rgb_to_hsv (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_ready,
  input  rgbhsv_pkg::pixel_t pixel,
  output logic               hsv_valid,
  input  logic               hsv_ready,
  output rgbhsv_pkg::hsv_t   hsv
);

  localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
  localparam int NB = rgbhsv_pkg::NUM_BITS;
  localparam int QB = rgbhsv_pkg::QUO_BITS;
  localparam int RB = rgbhsv_pkg::RESULT_BITS;

  // The pipeline moves whenever the output register is empty or being drained.
  // A new pixel therefore enters in the same cycle that a finished one leaves.
  logic en;
  assign en          = !hsv_valid || hsv_ready;
  assign pixel_ready = en;

  // The first two stages find the extrema, pick the hue sector and build the
  // numerators and divisors of both quotients.
  rgbhsv_pkg::front_t front;

  rgbhsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .front       (front)
  );

  // Hue divides the sector numerator by six times the spread; the extra quotient
  // bit below the result is used for round-to-nearest with ties up.
  logic [QB-1:0] hue_quo;
  logic [QB-1:0] sat_quo;

  rgbhsv_divider #(
    .DEN_BITS (NB),
    .QUO_BITS (QB)
  ) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (front.hue_num),
    .den (front.hue_den),
    .quo (hue_quo)
  );

  // Saturation divides the spread by the brightness.
  rgbhsv_divider #(
    .DEN_BITS (CB),
    .QUO_BITS (QB)
  ) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (front.sat_num),
    .den (front.brightness),
    .quo (sat_quo)
  );

  // Sideband line running alongside the divider stages, one entry per stage.
  logic          side_valid [QB];
  logic          side_grey  [QB];
  logic [CB-1:0] side_bright[QB];
  logic [CB-1:0] side_alpha [QB];

  for (genvar s = 0; s < QB; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          side_valid[s] <= 1'b0;
        end else if (en) begin
          side_valid[s] <= front.valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          side_grey[s]   <= front.grey;
          side_bright[s] <= front.brightness;
          side_alpha[s]  <= front.opacity;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          side_valid[s] <= 1'b0;
        end else if (en) begin
          side_valid[s] <= side_valid[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          side_grey[s]   <= side_grey[s-1];
          side_bright[s] <= side_bright[s-1];
          side_alpha[s]  <= side_alpha[s-1];
        end
      end
    end
  end

  // Rounding: with k the quotient carrying one extra fraction bit, the rounded
  // result is (k + 1) / 2. The largest k is 2^(FRACTION_BITS+1), so the sum fits.
  // A grey pixel has a zero divisor, and its quotients are replaced by zero.
  logic [QB-1:0]     hue_sum;
  logic [QB-1:0]     sat_sum;
  rgbhsv_pkg::hsv_t  hsv_next;

  always_comb begin
    hue_sum                 = hue_quo + QB'(1);
    sat_sum                 = sat_quo + QB'(1);
    hsv_next.hue            = side_grey[QB-1] ? '0 : hue_sum[QB-1:1];
    hsv_next.saturation     = side_grey[QB-1] ? '0 : sat_sum[QB-1:1];
    hsv_next.brightness     = side_bright[QB-1];
    hsv_next.opacity_out    = side_alpha[QB-1];
  end

  // Output register: the beat stays here until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_valid <= 1'b0;
    end else if (en) begin
      hsv_valid <= side_valid[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsv <= hsv_next;
    end
  end

  // Zero saturation only arises for a grey pixel, which also has zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (hsv.saturation == '0) |-> (hsv.hue == '0))
    else $error("non-zero hue on a pixel with zero saturation");

  // Black has no saturation.
  a_black_sat: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && (hsv.brightness == '0) |-> (hsv.saturation == '0))
    else $error("saturation set on a black pixel");

  // Neither quotient may exceed one.
  a_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> (hsv.hue <= (RB'(1) << (RB - 1)))
                  && (hsv.saturation <= (RB'(1) << (RB - 1))))
    else $error("hue or saturation above full scale");

  // While the output stalls the divider inputs must not move.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |=> $stable(front))
    else $error("front end advanced during a stall");

endmodule

[tb/tb_rgb_to_hsv.sv]
// Self-checking testbench for rgb_to_hsv: directed and random pixels checked against a scoreboard.
module tb_rgb_to_hsv;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
  localparam int FB = rgbhsv_pkg::FRACTION_BITS;
  localparam int RB = rgbhsv_pkg::RESULT_BITS;

  // Cycles from input beat to output beat through the top level.
  localparam int PIPE_LATENCY   = FB + 5;
  // Consecutive cycles without any beat on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PIXELS  = 1100;
  localparam logic [CB-1:0] FULL = '1;

  // The scoreboard predicts the HSV beat of every accepted pixel and checks the
  // output beats against those predictions in order.
  class hsv_scoreboard;
    rgbhsv_pkg::hsv_t expected_hsv[$];
    int   errors = 0;
    int   checked = 0;

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Bit-exact conversion of one pixel. The minimum component chooses the hue
    // sector; red wins a tie for the minimum, then green.
    function rgbhsv_pkg::hsv_t convert_pixel(rgbhsv_pkg::pixel_t p);
      logic [63:0]      r, g, b, v, lo, d, num;
      logic [1:0]       sector;
      rgbhsv_pkg::hsv_t h;
      r = 64'(p.red);
      g = 64'(p.green);
      b = 64'(p.blue);
      v = (r > g) ? r : g;
      v = (v > b) ? v : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      h.hue         = '0;
      h.saturation  = '0;
      h.brightness  = v[CB-1:0];
      h.opacity_out = p.opacity;
      if (v != lo) begin
        d = v - lo;
        if (r == lo) sector = rgbhsv_pkg::SEC_RED;
        else if (g == lo) sector = rgbhsv_pkg::SEC_GREEN;
        else sector = rgbhsv_pkg::SEC_BLUE;
        case (sector)
          rgbhsv_pkg::SEC_RED:   num = 3 * d + b - g;
          rgbhsv_pkg::SEC_GREEN: num = 5 * d + r - b;
          default:               num = d + g - r;
        endcase
        // Rounded to nearest with ties upwards: (2n + q) / 2q.
        h.hue        = RB'(((num << (FB + 1)) + 6 * d) / (12 * d));
        h.saturation = RB'(((d << (FB + 1)) + v) / (2 * v));
      end
      return h;
    endfunction

    function void note_pixel(rgbhsv_pkg::pixel_t p);
      expected_hsv.push_back(convert_pixel(p));
    endfunction

    task check_result(rgbhsv_pkg::hsv_t got);
      rgbhsv_pkg::hsv_t want;
      if (expected_hsv.size() == 0) begin
        report($sformatf("output beat %h with no pixel outstanding", got));
      end else begin
        want = expected_hsv.pop_front();
        if (got.hue !== want.hue)
          report($sformatf("beat %0d hue %0d, expected %0d", checked, got.hue, want.hue));
        if (got.saturation !== want.saturation)
          report($sformatf("beat %0d saturation %0d, expected %0d", checked,
                           got.saturation, want.saturation));
        if (got.brightness !== want.brightness)
          report($sformatf("beat %0d brightness %0d, expected %0d", checked,
                           got.brightness, want.brightness));
        if (got.opacity_out !== want.opacity_out)
          report($sformatf("beat %0d opacity %0d, expected %0d", checked,
                           got.opacity_out, want.opacity_out));
      end
      checked++;
    endtask

    function int pending();
      return expected_hsv.size();
    endfunction
  endclass

  // Every input of the block starts from a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               pixel_valid = 1'b0;
  logic               pixel_ready;
  rgbhsv_pkg::pixel_t pixel = '0;
  logic               hsv_valid;
  logic               hsv_ready = 1'b0;
  rgbhsv_pkg::hsv_t   hsv;

  // Percentages of cycles in which the sender and the receiver hold back.
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 77;
  int unsigned quiet_cycles = 0;

  hsv_scoreboard sb = new();

  rgb_to_hsv u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_ready   (hsv_ready),
    .hsv         (hsv)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether it will take a beat,
  // so its stalls land on every stage of the pipeline.
  always @(negedge clk) begin
    hsv_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Output beats are sampled at the rising edge, before any register update
  // of that edge has taken effect.
  always @(posedge clk) begin
    if (!rst && hsv_valid && hsv_ready) begin
      sb.check_result(hsv);
    end
  end

  // The watchdog only counts cycles in which neither channel moves a beat, so a
  // slow but live run is never cut short.
  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (hsv_valid && hsv_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog expired with %0d results outstanding", $time, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one pixel, called at a falling edge. Idle cycles come first, then
  // valid rises and stays up with the payload held until the beat is taken. Each
  // falling edge sees only one assignment to valid, so back-to-back beats keep
  // valid high throughout.
  task send_pixel(rgbhsv_pkg::pixel_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (!pixel_ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task send_rgba(int unsigned r, int unsigned g, int unsigned b, int unsigned a);
    rgbhsv_pkg::pixel_t p;
    p.red     = r[CB-1:0];
    p.green   = g[CB-1:0];
    p.blue    = b[CB-1:0];
    p.opacity = a[CB-1:0];
    send_pixel(p);
  endtask

  function logic [CB-1:0] random_component();
    logic [CB-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = '0;
      1:       c = FULL;
      default: c = CB'($urandom());
    endcase
    return c;
  endfunction

  // Mostly uniform pixels, with a share of greys, ties between two components and
  // pixels built from the extremes of the range.
  function rgbhsv_pkg::pixel_t random_pixel();
    rgbhsv_pkg::pixel_t p;
    p.red     = CB'($urandom());
    p.green   = CB'($urandom());
    p.blue    = CB'($urandom());
    p.opacity = CB'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: p.green = p.red;
      2: p.blue  = p.red;
      3: p.blue  = p.green;
      4: begin
        p.red   = random_component();
        p.green = random_component();
        p.blue  = random_component();
      end
      default: ;
    endcase
    return p;
  endfunction

  initial begin
    // Reset is held from the start and released at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First phase: the sender rarely idles while the receiver often stalls.
    send_idle_pct = 17;
    recv_idle_pct = 77;

    // Grey pixels, black and white among them, give zero hue and saturation.
    send_rgba(0, 0, 0, 0);
    send_rgba(255, 255, 255, 255);
    send_rgba(128, 128, 128, 1);
    // The primaries and secondaries visit every sector. Pure red has green and
    // blue tied for the minimum, so green takes it and hue lands on full scale.
    send_rgba(255, 0, 0, 255);
    send_rgba(0, 255, 0, 0);
    send_rgba(0, 0, 255, 170);
    send_rgba(255, 255, 0, 85);
    send_rgba(0, 255, 255, 255);
    send_rgba(255, 0, 255, 0);
    // Ties for the minimum: red before green, green before blue.
    send_rgba(10, 10, 200, 17);
    send_rgba(10, 200, 10, 34);
    send_rgba(200, 10, 10, 51);
    // The smallest non-zero spread, at both ends of the range.
    send_rgba(1, 0, 0, 255);
    send_rgba(0, 0, 1, 0);
    send_rgba(255, 254, 254, 128);
    send_rgba(254, 255, 255, 127);
    // Red just above its sector boundary, close to hue zero and full scale.
    send_rgba(255, 0, 1, 64);
    send_rgba(255, 1, 0, 192);
    // Full saturation with the maximum at its smallest, and a large spread.
    send_rgba(0, 1, 1, 3);
    send_rgba(255, 0, 128, 252);
    send_rgba(85, 170, 255, 200);

    repeat (RANDOM_PIXELS / 3) send_pixel(random_pixel());

    // Second phase: a slow sender facing an eager receiver.
    send_idle_pct = 77;
    recv_idle_pct = 17;
    repeat (RANDOM_PIXELS / 3) send_pixel(random_pixel());

    // Third phase: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PIXELS - 2 * (RANDOM_PIXELS / 3)) send_pixel(random_pixel());

    pixel_valid <= 1'b0;

    // Drain the pipeline, then keep the clock running so that any stray beat can show itself.
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
